>>> hdl/trwd_pkg.sv
package trwd_pkg;

  localparam int unsigned MATRIX_WORDS     = 9;
  localparam int unsigned QUATERNION_WORDS = 4;
  localparam int unsigned POS_WORDS        = 3;
  localparam int unsigned ANGLE_WORDS      = 3;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned COMP_W  = 5;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned FMT_W   = 3;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [COMP_W-1:0] COMP_POS_BASE    = 5'd0;
  localparam logic [COMP_W-1:0] COMP_ANGLE_BASE  = 5'd3;
  localparam logic [COMP_W-1:0] COMP_MATRIX_BASE = 5'd6;
  localparam logic [COMP_W-1:0] COMP_QUAT_BASE   = 5'd15;

  // Register index in the configuration space (byte address / 4).
  localparam logic [PADDR_W-3:0] REG_RECORD_FORMAT = 1'b0;

  typedef enum logic [FMT_W-1:0] {
    FMT_NONE       = 3'd0,
    FMT_POS        = 3'd1,
    FMT_ANGLES     = 3'd2,
    FMT_MATRIX     = 3'd3,
    FMT_POS_ANGLES = 3'd4,
    FMT_POS_MATRIX = 3'd5,
    FMT_QUAT       = 3'd6,
    FMT_POS_QUAT   = 3'd7
  } fmt_t;

  localparam fmt_t FMT_RESET = FMT_POS;

  // Shape of one record: leading position words, then a tail block.
  typedef struct packed {
    logic                known;
    logic [INDEX_W-1:0]  pos_len;
    logic [COMP_W-1:0]   tail_base;
    logic [INDEX_W-1:0]  tail_len;
  } layout_t;

  function automatic layout_t layout_of(fmt_t fmt);
    layout_t l;
    l.known     = 1'b1;
    l.pos_len   = '0;
    l.tail_base = '0;
    l.tail_len  = '0;
    case (fmt)
      FMT_POS: begin
        l.pos_len = INDEX_W'(POS_WORDS);
      end
      FMT_ANGLES: begin
        l.tail_base = COMP_ANGLE_BASE;
        l.tail_len  = INDEX_W'(ANGLE_WORDS);
      end
      FMT_MATRIX: begin
        l.tail_base = COMP_MATRIX_BASE;
        l.tail_len  = INDEX_W'(MATRIX_WORDS);
      end
      FMT_POS_ANGLES: begin
        l.pos_len   = INDEX_W'(POS_WORDS);
        l.tail_base = COMP_ANGLE_BASE;
        l.tail_len  = INDEX_W'(ANGLE_WORDS);
      end
      FMT_POS_MATRIX: begin
        l.pos_len   = INDEX_W'(POS_WORDS);
        l.tail_base = COMP_MATRIX_BASE;
        l.tail_len  = INDEX_W'(MATRIX_WORDS);
      end
      FMT_QUAT: begin
        l.tail_base = COMP_QUAT_BASE;
        l.tail_len  = INDEX_W'(QUATERNION_WORDS);
      end
      FMT_POS_QUAT: begin
        l.pos_len   = INDEX_W'(POS_WORDS);
        l.tail_base = COMP_QUAT_BASE;
        l.tail_len  = INDEX_W'(QUATERNION_WORDS);
      end
      default: begin
        l.known = 1'b0;
      end
    endcase
    return l;
  endfunction

endpackage

>>> hdl/tracker_record_word_deframer.sv
// Record word deframer for a motion tracker stream. Each input transaction
// carries one raw 16-bit word: bit 7 is the frame bit, bits 6..0 and 15..8
// are data. The block returns exactly one output transaction per word with
// the frame bit reported, the data packed into a signed 16-bit value
// ((high byte << 9) | (low seven bits << 2), truncated to 16 bits), the
// component the word carries under the current record format, and a flag on
// the record's last word. Formats 1 to 7 select position, angles, matrix,
// position+angles, position+matrix, quaternion and position+quaternion
// records; format 0 is unknown and gives value 0, component 0, last_word 1
// and format_error 1 on every word. The frame bit is reported only and never
// resynchronizes the word counter. If the format is changed mid-record so
// the counter lies past the new record length, the next word starts a new
// record. out_valid rises in the cycle after a word is accepted; one word can be
// accepted every cycle, limited only by the single output register, which
// frees up in the same cycle its transaction is taken. The record_format
// register (reset 1) sits at byte address 0 of the APB-style port and may be
// changed only while no transaction is in flight.
module tracker_record_word_deframer
  import trwd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // Configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready,
  // Input words.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [DATA_W-1:0]         data_word,
  // Results.
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DATA_W-1:0]  value,
  output logic [COMP_W-1:0]         component,
  output logic                      frame_flag,
  output logic                      last_word,
  output logic                      format_error
);

  fmt_t                record_format;
  logic [INDEX_W-1:0]  word_index;
  logic [INDEX_W-1:0]  word_index_next;
  logic                reg_sel;
  logic                cfg_write;
  logic                in_take;

  layout_t             layout;
  logic [INDEX_W-1:0]  rec_len;
  logic [INDEX_W-1:0]  idx;
  logic [INDEX_W-1:0]  idx_inc;
  logic [COMP_W-1:0]   comp_next;
  logic                last_next;
  logic [DATA_W-1:0]   packed_word;

  // The only register decodes at index 0; other addresses read as zero and
  // ignore writes.
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[PADDR_W-1:2] == REG_RECORD_FORMAT);
  assign cfg_write = psel && penable && pwrite && pready && reg_sel;
  assign prdata    = reg_sel ? {{(PDATA_W-FMT_W){1'b0}}, record_format} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_format <= FMT_RESET;
    end else if (cfg_write) begin
      record_format <= fmt_t'(pwdata[FMT_W-1:0]);
    end
  end

  // The output register is free when empty or when its transaction is being
  // taken in this same cycle, so words stream back to back.
  assign in_ready = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  assign layout  = layout_of(record_format);
  assign rec_len = layout.pos_len + layout.tail_len;
  // A counter stranded past the record end by a format change restarts.
  assign idx     = (word_index >= rec_len) ? '0 : word_index;
  assign idx_inc = idx + 1'b1;

  always_comb begin
    if (idx < layout.pos_len) begin
      comp_next = COMP_POS_BASE + COMP_W'(idx);
    end else begin
      comp_next = layout.tail_base + COMP_W'(idx - layout.pos_len);
    end
  end

  assign last_next = !layout.known || (idx_inc == rec_len);

  always_comb begin
    if (last_next) begin
      word_index_next = '0;
    end else begin
      word_index_next = idx_inc;
    end
  end

  // Frame bit dropped; the top bit of the high byte falls off the word.
  assign packed_word = {data_word[14:8], data_word[6:0], 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_take) begin
        word_index <= word_index_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      frame_flag   <= data_word[7];
      format_error <= !layout.known;
      last_word    <= last_next;
      if (layout.known) begin
        value     <= signed'(packed_word);
        component <= comp_next;
      end else begin
        value     <= '0;
        component <= '0;
      end
    end
  end

endmodule

>>> hdl/trwd_checker.sv
module trwd_checker
  import trwd_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [DATA_W-1:0]  value,
  input logic [COMP_W-1:0]         component,
  input logic                      last_word,
  input logic                      format_error
);

  // An unknown format always yields a zeroed, record-ending result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && format_error |-> last_word && value == '0 && component == '0)
    else $error("format error result not zeroed or not last");

  // Known formats never tag past the last quaternion element.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !format_error |-> component <= 5'd18)
    else $error("component out of range");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(component))
    else $error("stalled result changed");

  // The block never stalls input while its output side is empty or draining.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with output free");

  // Every accepted word shows up as a result in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

endmodule

bind tracker_record_word_deframer trwd_checker u_trwd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .value        (value),
  .component    (component),
  .last_word    (last_word),
  .format_error (format_error)
);

>>> tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import trwd_pkg::*;

  // The run stops here even if the block hangs. The slowest correct run is
  // about 2100 words, each waiting out a long sender gap and a long stall on
  // the result side, plus the register traffic between phases, and this limit
  // still leaves a wide margin.
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_WORDS = 2000;

  // Byte address of the record format register on the configuration port.
  localparam logic [PADDR_W-1:0] FMT_ADDR = {REG_RECORD_FORMAT, 2'b00};

  // One decoded word as the block should report it.
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [COMP_W-1:0]        component;
    logic                     frame_flag;
    logic                     last_word;
    logic                     format_error;
  } deframed_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [PDATA_W-1:0]       pwdata;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;
  logic                     in_valid;
  logic                     in_ready;
  logic [DATA_W-1:0]        data_word;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] value;
  logic [COMP_W-1:0]        component;
  logic                     frame_flag;
  logic                     last_word;
  logic                     format_error;

  // Our own copy of the block's state: the format it was last given and the
  // position of the next word inside the current record.
  fmt_t               cur_format;
  logic [INDEX_W-1:0] rec_pos;

  // Decoded words that the block still owes us, oldest first.
  deframed_t expected_words[$];
  deframed_t head_word;

  int  errors;
  int  cycle_count;
  // When set, the sender drives words back to back with no gaps.
  bit  tx_no_gaps;

  tracker_record_word_deframer u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_word    (data_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .component    (component),
    .frame_flag   (frame_flag),
    .last_word    (last_word),
    .format_error (format_error)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // A record is a run of leading position words followed by a tail block of
  // angles, matrix elements or quaternion elements. Returns 0 for a format
  // that has no known layout.
  function automatic bit record_shape(input fmt_t f, output int pos_n,
                                      output logic [COMP_W-1:0] tail_base,
                                      output int tail_n);
    pos_n     = 0;
    tail_base = COMP_POS_BASE;
    tail_n    = 0;
    case (f)
      FMT_POS: begin
        pos_n = POS_WORDS;
      end
      FMT_ANGLES: begin
        tail_base = COMP_ANGLE_BASE;
        tail_n    = ANGLE_WORDS;
      end
      FMT_MATRIX: begin
        tail_base = COMP_MATRIX_BASE;
        tail_n    = MATRIX_WORDS;
      end
      FMT_POS_ANGLES: begin
        pos_n     = POS_WORDS;
        tail_base = COMP_ANGLE_BASE;
        tail_n    = ANGLE_WORDS;
      end
      FMT_POS_MATRIX: begin
        pos_n     = POS_WORDS;
        tail_base = COMP_MATRIX_BASE;
        tail_n    = MATRIX_WORDS;
      end
      FMT_QUAT: begin
        tail_base = COMP_QUAT_BASE;
        tail_n    = QUATERNION_WORDS;
      end
      FMT_POS_QUAT: begin
        pos_n     = POS_WORDS;
        tail_base = COMP_QUAT_BASE;
        tail_n    = QUATERNION_WORDS;
      end
      default: begin
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // Words per record; an unknown format ends a record on every word.
  function automatic int record_len(input fmt_t f);
    int                pos_n;
    int                tail_n;
    logic [COMP_W-1:0] tail_base;
    if (!record_shape(f, pos_n, tail_base, tail_n))
      return 1;
    return pos_n + tail_n;
  endfunction

  // Decodes one accepted word and advances the record position.
  function automatic deframed_t decode_word(input logic [DATA_W-1:0] w);
    deframed_t         r;
    int                pos_n;
    int                tail_n;
    int                idx;
    logic [COMP_W-1:0] tail_base;
    r.frame_flag = w[7];
    if (!record_shape(cur_format, pos_n, tail_base, tail_n)) begin
      r.value        = '0;
      r.component    = '0;
      r.last_word    = 1'b1;
      r.format_error = 1'b1;
      rec_pos        = '0;
      return r;
    end
    // A counter left past the end of a shorter record restarts the record.
    idx = rec_pos;
    if (idx >= pos_n + tail_n)
      idx = 0;
    if (idx < pos_n)
      r.component = COMP_POS_BASE + COMP_W'(idx);
    else
      r.component = tail_base + COMP_W'(idx - pos_n);
    r.last_word    = (idx + 1 == pos_n + tail_n);
    r.format_error = 1'b0;
    rec_pos        = r.last_word ? '0 : INDEX_W'(idx + 1);
    // The frame bit is dropped; the high byte lands at bit 9 and its top bit
    // falls off the 16-bit result.
    r.value = {w[14:8], w[6:0], 2'b00};
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 95)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly random words, with the field extremes mixed in.
  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 19))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0080;
      3:       return 16'hFF7F;
      default: return DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Words left to finish the record in progress under the current format.
  function automatic int words_to_boundary();
    int len;
    len = record_len(cur_format);
    if (rec_pos >= len)
      return 0;
    return (len - rec_pos) % len;
  endfunction

  // Sends one word as an input transaction, after an optional idle gap. The
  // expectation is formed at the edge where the transaction is accepted.
  task automatic send_word(input logic [DATA_W-1:0] w);
    int gap;
    gap = tx_no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  = 1'b1;
    data_word = w;
    do @(posedge clk); while (!in_ready);
    expected_words.push_back(decode_word(w));
  endtask

  // Stops the sender and waits until every expected output transaction has
  // been seen, plus a little margin.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr,
                           input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr,
                          output logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Reads the format register back and compares its low bits.
  task automatic check_record_format(input fmt_t want);
    logic [PDATA_W-1:0] rd;
    apb_read(FMT_ADDR, rd);
    if (rd[FMT_W-1:0] !== want) begin
      errors++;
      $display("%0t: record_format readback mismatch, expected %0d, actual %0d",
               $time, want, rd[FMT_W-1:0]);
    end
  endtask

  // Reprograms the format once the block has drained. The upper data bits
  // carry noise, since only the low three bits belong to the register.
  task automatic set_record_format(input fmt_t f);
    logic [PDATA_W-1:0] data;
    wait_idle();
    data            = $urandom;
    data[FMT_W-1:0] = f;
    apb_write(FMT_ADDR, data);
    cur_format = f;
    check_record_format(f);
  endtask

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------

  task automatic report_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Every output transaction is matched against the oldest expectation. The
  // outputs are read at the rising edge, before the block updates them.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: output transaction with nothing expected, expected none, actual %0d/%0d",
                 $time, value, component);
      end else begin
        head_word = expected_words.pop_front();
        report_field("value", head_word.value, value);
        report_field("component", head_word.component, component);
        report_field("frame_flag", head_word.frame_flag, frame_flag);
        report_field("last_word", head_word.last_word, last_word);
        report_field("format_error", head_word.format_error, format_error);
      end
    end
  end

  // The result side accepts for a random stretch, then stalls for a random
  // gap. Short stretches of constant readiness come up regularly.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      out_ready = 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Guards against a block that stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // The register must come out of reset as position records. Two position
  // records carry the extremes of the word, with the frame bit both ways.
  task automatic test_reset_state();
    check_record_format(FMT_RESET);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h0080);
    send_word(16'hFF7F);
    send_word(16'h8000);
    send_word(16'h007F);
  endtask

  // Two words under each remaining known format. The record position is
  // carried across the format changes, so later tail elements show up too.
  task automatic test_each_format();
    int i;
    for (i = FMT_ANGLES; i <= FMT_POS_QUAT; i++) begin
      set_record_format(fmt_t'(i));
      send_word(random_word());
      send_word(random_word());
    end
  endtask

  // An unknown format zeroes value and component, flags every word as last
  // and as an error, still reports the frame bit, and clears the position.
  task automatic test_unknown_format();
    set_record_format(FMT_NONE);
    send_word(16'h0080);
    send_word(16'hFFFF);
  endtask

  // Leave a matrix record four words in, with frame bits set to show they do
  // not resynchronize anything, then switch to position records. The stale
  // position lies past the shorter record, so the next word starts afresh.
  task automatic test_format_change_mid_record();
    set_record_format(FMT_MATRIX);
    repeat (4) send_word(random_word() | 16'h0080);
    set_record_format(FMT_POS);
    send_word(random_word());
    send_word(random_word());
  endtask

  // Phases of random length. Most phases finish the record in progress and
  // then send whole records; the rest send broken, partial runs. The format
  // usually changes between phases and is now and then unknown.
  task automatic test_random_records();
    int   sent;
    int   n;
    fmt_t f;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 4) != 0) begin
        f = ($urandom_range(0, 11) == 0) ? FMT_NONE : fmt_t'($urandom_range(1, 7));
        set_record_format(f);
      end
      tx_no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7)
        n = words_to_boundary() + record_len(cur_format) * $urandom_range(1, 3);
      else
        n = $urandom_range(1, 15);
      repeat (n) send_word(random_word());
      sent += n;
    end
    tx_no_gaps = 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    data_word   = '0;
    tx_no_gaps  = 1'b0;
    errors      = 0;
    cycle_count = 0;
    cur_format  = FMT_RESET;
    rec_pos     = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_each_format();
    test_unknown_format();
    test_format_change_mid_record();
    test_random_records();

    // Drain the last results, then keep watching in case the block emits
    // anything unasked for.
    wait_idle();
    repeat (4) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
